// File: sv/rppa_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Radar pulse packet assembler package
// Shared payload types, configuration view, codes and size constants.
// ----------------------------------------------------------------------------
package rppa_pkg;

  localparam int unsigned MAX_PACKETS = 1024;
  localparam int unsigned PKT_CNT_W   = $clog2(MAX_PACKETS + 1);
  localparam int unsigned SLOT_W      = 10;
  localparam int unsigned CNT_W       = 32;
  localparam int unsigned SERIAL_W    = 32;
  localparam int unsigned APB_DATA_W  = 32;
  localparam int unsigned APB_ADDR_W  = 3;

  typedef enum logic [1:0] {
    ST_NONE     = 2'd0,
    ST_TIMEOUT  = 2'd1,
    ST_OVERFLOW = 2'd2,
    ST_ERROR    = 2'd3
  } link_status_e;

  typedef enum logic [1:0] {
    ACT_DROP   = 2'd0,
    ACT_HEADER = 2'd1,
    ACT_DATA   = 2'd2
  } action_e;

  typedef enum logic [2:0] {
    END_NONE    = 3'd0,
    END_CLEAN   = 3'd1,
    END_FAULTY  = 3'd2,
    END_TIMEOUT = 3'd3,
    END_ERROR   = 3'd4
  } pulse_end_e;

  typedef enum logic {
    REG_PACKETS_IN_PULSE = 1'b0,
    REG_RAW_MODE         = 1'b1
  } reg_idx_e;

  typedef struct packed {
    logic [1:0]          link_status;
    logic                full_length;
    logic [SERIAL_W-1:0] serial_number;
    logic                is_header;
  } in_item_t;

  typedef struct packed {
    logic [1:0]       action;
    logic [SLOT_W-1:0] slot_index;
    logic [2:0]       pulse_end;
    logic [CNT_W-1:0] overrun_count;
    logic [CNT_W-1:0] short_read_count;
    logic [CNT_W-1:0] lost_packet_count;
    logic [CNT_W-1:0] framing_error_count;
  } out_item_t;

  typedef struct packed {
    logic [10:0] packets_in_pulse;
    logic        raw_mode;
  } cfg_t;

endpackage

// File: sv/rppa_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Configuration registers
// APB-style write/read port for pulse length and raw mode.
// ----------------------------------------------------------------------------
module rppa_regs import rppa_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready,
  output cfg_t                  cfg_o
);

  cfg_t     cfg_q, cfg_d;
  reg_idx_e idx;
  logic     wr_en;

  assign pready = 1'b1;
  assign idx    = reg_idx_e'(paddr[2]);
  assign wr_en  = psel && penable && pwrite && pready;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (idx)
        REG_PACKETS_IN_PULSE: cfg_d.packets_in_pulse = pwdata[10:0];
        REG_RAW_MODE:         cfg_d.raw_mode         = pwdata[0];
        default:              cfg_d                  = cfg_q;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_PACKETS_IN_PULSE: prdata = {21'd0, cfg_q.packets_in_pulse};
      REG_RAW_MODE:         prdata = {31'd0, cfg_q.raw_mode};
      default:              prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.packets_in_pulse <= 11'd1;
      cfg_q.raw_mode         <= 1'b0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// File: sv/rppa_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pulse assembly core
// Judges one packet descriptor per cycle against pulse state and counters
// while the result register is free or taken, then loads that register.
// ----------------------------------------------------------------------------
module rppa_core import rppa_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  cfg_t      cfg_i,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_item_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_item_t out_data_o
);

  logic [SERIAL_W-1:0]  exp_q, exp_d;
  logic [PKT_CNT_W-1:0] pkts_q, pkts_d;
  logic                 clean_q, clean_d;
  logic [CNT_W-1:0]     ovr_q, ovr_d;
  logic [CNT_W-1:0]     short_q, short_d;
  logic [CNT_W-1:0]     lost_q, lost_d;
  logic [CNT_W-1:0]     frm_q, frm_d;
  logic                 out_valid_q;
  out_item_t            out_q, out_d;

  logic                 xfer;
  logic                 judge;
  logic [PKT_CNT_W-1:0] len;
  logic [PKT_CNT_W-1:0] pkts_inc;
  action_e              act;
  pulse_end_e           pend;
  logic [SLOT_W-1:0]    slot;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign xfer       = in_valid_i && in_ready_o;

  always_comb begin
    if (cfg_i.packets_in_pulse == '0) begin
      len = PKT_CNT_W'(1);
    end else if (cfg_i.packets_in_pulse > PKT_CNT_W'(MAX_PACKETS)) begin
      len = PKT_CNT_W'(MAX_PACKETS);
    end else begin
      len = PKT_CNT_W'(cfg_i.packets_in_pulse);
    end
  end

  always_comb begin
    exp_d    = exp_q;
    pkts_d   = pkts_q;
    clean_d  = clean_q;
    ovr_d    = ovr_q;
    short_d  = short_q;
    lost_d   = lost_q;
    frm_d    = frm_q;
    judge    = 1'b1;
    act      = ACT_DROP;
    pend     = END_NONE;
    slot     = '0;
    pkts_inc = '0;

    case (link_status_e'(in_data_i.link_status))
      ST_TIMEOUT, ST_ERROR: begin
        pend    = (link_status_e'(in_data_i.link_status) == ST_TIMEOUT) ?
                  END_TIMEOUT : END_ERROR;
        pkts_d  = '0;
        clean_d = 1'b1;
        judge   = 1'b0;
      end
      ST_OVERFLOW: begin
        ovr_d   = ovr_q + 1'b1;
        clean_d = 1'b0;
        judge   = 1'b0;
      end
      default: begin
        if (!in_data_i.full_length) begin
          short_d = short_q + 1'b1;
          clean_d = 1'b0;
          judge   = 1'b0;
        end else if (in_data_i.serial_number != exp_q) begin
          lost_d  = lost_q + (in_data_i.serial_number - exp_q - 1'b1);
          exp_d   = in_data_i.serial_number + 1'b1;
          clean_d = 1'b0;
          if (pkts_q != '0 && !cfg_i.raw_mode) begin
            pkts_d = '0;
            judge  = 1'b0;
          end
        end else begin
          exp_d = in_data_i.serial_number + 1'b1;
        end
      end
    endcase

    if (judge) begin
      if (cfg_i.raw_mode) begin
        act = in_data_i.is_header ? ACT_HEADER : ACT_DATA;
      end else if (pkts_q == '0) begin
        if (in_data_i.is_header) begin
          act = ACT_HEADER;
        end else begin
          frm_d   = frm_q + 1'b1;
          clean_d = 1'b0;
        end
      end else begin
        if (!in_data_i.is_header) begin
          act = ACT_DATA;
        end else begin
          frm_d   = frm_q + 1'b1;
          pkts_d  = '0;
          clean_d = 1'b0;
        end
      end
      if (act != ACT_DROP) begin
        slot     = pkts_q[SLOT_W-1:0];
        pkts_inc = pkts_q + 1'b1;
        if (pkts_inc >= len) begin
          pend    = clean_d ? END_CLEAN : END_FAULTY;
          pkts_d  = '0;
          clean_d = 1'b1;
        end else begin
          pkts_d = pkts_inc;
        end
      end
    end

    out_d.action              = act;
    out_d.slot_index          = slot;
    out_d.pulse_end           = pend;
    out_d.overrun_count       = ovr_d;
    out_d.short_read_count    = short_d;
    out_d.lost_packet_count   = lost_d;
    out_d.framing_error_count = frm_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      exp_q       <= '0;
      pkts_q      <= '0;
      clean_q     <= 1'b1;
      ovr_q       <= '0;
      short_q     <= '0;
      lost_q      <= '0;
      frm_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (xfer) begin
        exp_q   <= exp_d;
        pkts_q  <= pkts_d;
        clean_q <= clean_d;
        ovr_q   <= ovr_d;
        short_q <= short_d;
        lost_q  <= lost_d;
        frm_q   <= frm_d;
      end
      if (xfer) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (xfer) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_pkts_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pkts_q < PKT_CNT_W'(MAX_PACKETS))
    else $error("packet count reached pulse capacity");

  a_end_resets_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && (out_q.pulse_end != END_NONE) |-> (pkts_q == '0) && clean_q)
    else $error("pulse end did not restart collection");

  a_fail_drops: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && (out_q.pulse_end == END_TIMEOUT || out_q.pulse_end == END_ERROR)
    |-> out_q.action == ACT_DROP)
    else $error("failed pulse end with accepted packet");

  a_header_slot0: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !cfg_i.raw_mode && (out_q.action == ACT_HEADER)
    |-> out_q.slot_index == '0)
    else $error("framed header not at slot zero");

endmodule

// File: sv/radar_pulse_packet_assembler_unit.sv
`timescale 1ns / 1ps
// Path: each input transfer is captured in the input register, then judged
//   by the core logic into its result register.
// Throughput: one packet descriptor per cycle while results are taken, as the
//   core updates its state on the same edge that loads the result register.
// Reset: rst_ni clears all counters, the expected serial and pulse state, and
//   sets packets_in_pulse to 1 and raw_mode to 0; no clearing pass.
// ----------------------------------------------------------------------------
// Radar pulse packet assembler
// Frames received packet descriptors into pulses and keeps link fault counters.
// ----------------------------------------------------------------------------
module radar_pulse_packet_assembler_unit import rppa_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  in_item_t              in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output out_item_t             out_data_o
);

  cfg_t     cfg;
  logic     in_valid_q;
  in_item_t in_q;
  logic     core_ready;

  assign in_ready_o = !in_valid_q || core_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_q <= in_data_i;
    end
  end

  rppa_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  rppa_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .in_valid_i  (in_valid_q),
    .in_ready_o  (core_ready),
    .in_data_i   (in_q),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

// File: tb/sv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Radar pulse packet assembler testbench
// Drives packet descriptors and APB register writes into the assembler,
// predicts each verdict (action, slot, pulse end, fault counters) in a
// scoreboard and compares every result transfer field by field.
// ----------------------------------------------------------------------------
module testbench;
  import rppa_pkg::*;

  class pulse_scoreboard;
    logic [10:0] pkts_cfg;
    logic        raw_cfg;
    logic [31:0] next_serial;
    logic [31:0] overruns;
    logic [31:0] short_reads;
    logic [31:0] lost_packets;
    logic [31:0] framing_errors;
    int unsigned collected;
    bit          clean;
    out_item_t   pending_verdicts[$];
    int          mismatches;

    function new();
      pkts_cfg       = 11'd1;
      raw_cfg        = 1'b0;
      next_serial    = '0;
      overruns       = '0;
      short_reads    = '0;
      lost_packets   = '0;
      framing_errors = '0;
      collected      = 0;
      clean          = 1'b1;
      mismatches     = 0;
    endfunction

    function void write_cfg(reg_idx_e idx, logic [31:0] value);
      if (idx == REG_PACKETS_IN_PULSE) begin
        pkts_cfg = value[10:0];
      end else begin
        raw_cfg = value[0];
      end
    endfunction

    function int unsigned pulse_len();
      if (pkts_cfg == 0) return 1;
      if (pkts_cfg > MAX_PACKETS) return MAX_PACKETS;
      return 32'(pkts_cfg);
    endfunction

    function int pending();
      return pending_verdicts.size();
    endfunction

    function void take_packet(in_item_t it);
      out_item_t v;
      bit        judge;
      v     = '0;
      judge = 1'b1;
      if (it.link_status == ST_TIMEOUT || it.link_status == ST_ERROR) begin
        v.pulse_end = (it.link_status == ST_TIMEOUT) ? END_TIMEOUT : END_ERROR;
        collected   = 0;
        clean       = 1'b1;
        judge       = 1'b0;
      end else if (it.link_status == ST_OVERFLOW) begin
        overruns++;
        clean = 1'b0;
        judge = 1'b0;
      end else if (!it.full_length) begin
        short_reads++;
        clean = 1'b0;
        judge = 1'b0;
      end else if (it.serial_number != next_serial) begin
        lost_packets += it.serial_number - next_serial - 32'd1;
        next_serial  = it.serial_number + 32'd1;
        clean        = 1'b0;
        if (collected > 0 && !raw_cfg) begin
          collected = 0;
          judge     = 1'b0;
        end
      end else begin
        next_serial = it.serial_number + 32'd1;
      end

      if (judge) begin
        if (raw_cfg) begin
          v.action = it.is_header ? ACT_HEADER : ACT_DATA;
        end else if (collected == 0) begin
          if (it.is_header) begin
            v.action = ACT_HEADER;
          end else begin
            framing_errors++;
            clean = 1'b0;
          end
        end else if (!it.is_header) begin
          v.action = ACT_DATA;
        end else begin
          framing_errors++;
          collected = 0;
          clean     = 1'b0;
        end
        if (v.action != ACT_DROP) begin
          v.slot_index = collected[9:0];
          collected++;
          if (collected >= pulse_len()) begin
            v.pulse_end = clean ? END_CLEAN : END_FAULTY;
            collected   = 0;
            clean       = 1'b1;
          end
        end
      end

      v.overrun_count       = overruns;
      v.short_read_count    = short_reads;
      v.lost_packet_count   = lost_packets;
      v.framing_error_count = framing_errors;
      pending_verdicts.push_back(v);
    endfunction

    task report(string what, logic [31:0] got, logic [31:0] want);
      mismatches++;
      if (mismatches <= 40) begin
        $display("%0t mismatch %s: got %0h expected %0h", $realtime, what, got, want);
      end
    endtask

    task check_verdict(out_item_t got);
      out_item_t want;
      if (pending_verdicts.size() == 0) begin
        report("unexpected result transfer", 32'd0, 32'd0);
        return;
      end
      want = pending_verdicts.pop_front();
      if (got.action !== want.action)
        report("action", 32'(got.action), 32'(want.action));
      if (got.slot_index !== want.slot_index)
        report("slot_index", 32'(got.slot_index), 32'(want.slot_index));
      if (got.pulse_end !== want.pulse_end)
        report("pulse_end", 32'(got.pulse_end), 32'(want.pulse_end));
      if (got.overrun_count !== want.overrun_count)
        report("overrun_count", got.overrun_count, want.overrun_count);
      if (got.short_read_count !== want.short_read_count)
        report("short_read_count", got.short_read_count, want.short_read_count);
      if (got.lost_packet_count !== want.lost_packet_count)
        report("lost_packet_count", got.lost_packet_count, want.lost_packet_count);
      if (got.framing_error_count !== want.framing_error_count)
        report("framing_error_count", got.framing_error_count,
               want.framing_error_count);
    endtask
  endclass

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [APB_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;
  logic                  in_valid_i;
  logic                  in_ready_o;
  in_item_t              in_data_i;
  logic                  out_valid_o;
  logic                  out_ready_i = 1'b0;
  out_item_t             out_data_o;

  pulse_scoreboard sb;
  int              send_idle_pct;
  int              recv_idle_pct;
  logic [31:0]     gen_serial;

  radar_pulse_packet_assembler_unit dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) sb.check_verdict(out_data_o);
      if (in_valid_i && in_ready_o) sb.take_packet(in_data_i);
    end
  end

  function automatic in_item_t descriptor(logic [1:0] status, logic full,
                                          logic [31:0] serial, logic hdr);
    in_item_t it;
    it.link_status   = status;
    it.full_length   = full;
    it.serial_number = serial;
    it.is_header     = hdr;
    return it;
  endfunction

  function automatic in_item_t noise_item();
    in_item_t    it;
    int unsigned pick;
    it.link_status = 2'($urandom_range(3));
    it.full_length = 1'($urandom_range(1));
    it.is_header   = 1'($urandom_range(1));
    pick = $urandom_range(3);
    if (pick < 2) it.serial_number = gen_serial;
    else if (pick == 2) it.serial_number = $urandom;
    else it.serial_number = gen_serial + $urandom_range(1, 3);
    return it;
  endfunction

  function automatic in_item_t with_fault(in_item_t it);
    in_item_t f;
    f = it;
    case ($urandom_range(7))
      0: f.link_status = ST_TIMEOUT;
      1: f.link_status = ST_ERROR;
      2: f.link_status = ST_OVERFLOW;
      3: f.full_length = 1'b0;
      4: f.serial_number = it.serial_number + $urandom_range(1, 5);
      5: f.serial_number = $urandom;
      6: f.is_header = ~it.is_header;
      default: f = noise_item();
    endcase
    return f;
  endfunction

  task send_item(in_item_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= it;
    if (it.link_status == ST_NONE && it.full_length) gen_serial = it.serial_number + 32'd1;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  // Hold the sender until every verdict is back.
  task wait_quiet();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task write_reg(reg_idx_e idx, logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    sb.write_cfg(idx, value);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
  endtask

  task configure(logic [31:0] pkts, logic raw);
    wait_quiet();
    write_reg(REG_PACKETS_IN_PULSE, pkts);
    write_reg(REG_RAW_MODE, {31'd0, raw});
  endtask

  task send_pulse(int unsigned len, int unsigned fault_pct);
    in_item_t it;
    for (int unsigned i = 0; i < len; i++) begin
      it = descriptor(ST_NONE, 1'b1, gen_serial, i == 0);
      if ($urandom_range(99) < fault_pct) it = with_fault(it);
      send_item(it);
    end
  endtask

  task run_random(int unsigned count, int unsigned fault_pct);
    int unsigned sent;
    int unsigned len;
    int unsigned plen;
    sent = 0;
    while (sent < count) begin
      if ($urandom_range(99) < 85) begin
        len = sb.pulse_len();
        if (len > 16) plen = $urandom_range(1, 20);
        else if ($urandom_range(3) == 0) plen = $urandom_range(1, len + 2);
        else plen = len;
        send_pulse(plen, fault_pct);
        sent += plen;
      end else begin
        send_item(noise_item());
        sent++;
      end
    end
  endtask

  initial begin
    int unsigned waited;
    sb            = new();
    send_idle_pct = 29;
    recv_idle_pct = 75;
    gen_serial    = '0;
    psel       <= 1'b0;
    penable    <= 1'b0;
    pwrite     <= 1'b0;
    paddr      <= '0;
    pwdata     <= '0;
    in_valid_i <= 1'b0;
    in_data_i  <= '0;
    rst_ni     <= 1'b0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_item(descriptor(ST_NONE, 1'b1, 32'd0, 1'b1));
    send_item(descriptor(ST_NONE, 1'b1, 32'd1, 1'b0));
    send_item(descriptor(ST_TIMEOUT, 1'b1, 32'd2, 1'b1));
    send_item(descriptor(ST_ERROR, 1'b0, 32'hffff_ffff, 1'b0));
    send_item(descriptor(ST_OVERFLOW, 1'b1, 32'd2, 1'b1));
    send_item(descriptor(ST_NONE, 1'b0, 32'd2, 1'b1));
    send_item(descriptor(ST_NONE, 1'b1, 32'hffff_fffe, 1'b1));
    send_item(descriptor(ST_NONE, 1'b1, 32'hffff_ffff, 1'b1));
    send_item(descriptor(ST_NONE, 1'b1, 32'd0, 1'b1));
    send_item(descriptor(ST_NONE, 1'b1, 32'd0, 1'b1));
    wait_quiet();
    write_reg(REG_PACKETS_IN_PULSE, 32'hffff_f804);
    send_item(descriptor(ST_NONE, 1'b1, 32'd1, 1'b1));
    send_item(descriptor(ST_NONE, 1'b1, 32'd2, 1'b0));
    send_item(descriptor(ST_NONE, 1'b1, 32'd3, 1'b1));
    send_item(descriptor(ST_NONE, 1'b1, 32'd4, 1'b1));
    send_item(descriptor(ST_NONE, 1'b1, 32'd6, 1'b0));
    send_item(descriptor(ST_NONE, 1'b1, 32'd7, 1'b1));
    send_item(descriptor(ST_NONE, 1'b1, 32'd8, 1'b0));
    send_item(descriptor(ST_TIMEOUT, 1'b1, 32'd9, 1'b0));
    send_item(descriptor(ST_NONE, 1'b1, 32'd9, 1'b1));
    send_item(descriptor(ST_NONE, 1'b1, 32'd10, 1'b0));
    send_item(descriptor(ST_NONE, 1'b1, 32'd11, 1'b0));
    wait_quiet();
    write_reg(REG_PACKETS_IN_PULSE, 32'd2);
    send_item(descriptor(ST_NONE, 1'b1, 32'd12, 1'b0));
    wait_quiet();
    write_reg(REG_RAW_MODE, 32'hffff_fffe);
    write_reg(REG_RAW_MODE, 32'd1);
    send_item(descriptor(ST_NONE, 1'b1, 32'd20, 1'b0));
    send_item(descriptor(ST_NONE, 1'b1, 32'd21, 1'b1));
    send_item(descriptor(ST_NONE, 1'b0, 32'd22, 1'b0));

    configure(32'd4, 1'b0);
    run_random(60, 8);
    configure(32'd0, 1'b1);
    run_random(25, 8);

    send_idle_pct = 75;
    recv_idle_pct = 29;
    configure(32'd2047, 1'b0);
    run_random(60, 8);
    configure(32'd7, 1'b1);
    run_random(25, 10);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    configure(32'd1024, 1'b0);
    send_pulse(1024, 0);
    run_random(20, 10);
    configure(32'd3, 1'b0);
    run_random(30, 12);
    wait_quiet();
    run_random(30, 12);

    in_valid_i <= 1'b0;
    @(posedge clk_i);
    waited = 0;
    while (sb.pending() != 0 && waited < 5000) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (10) @(posedge clk_i);
    if (sb.pending() != 0) sb.report("results never arrived", sb.pending(), 32'd0);
    if (sb.mismatches == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
